@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the top-level RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check an implication on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Check a next-cycle implication outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ hw/rtl/tshp_pkg.sv @@
// Package: payload types and constants for the ServerHello parser
`default_nettype none
package tshp_pkg;
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } tshp_in_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  key_byte;
    logic        status;
    logic [15:0] suite_id;
    logic        is_version_13;
    logic [15:0] key_group;
    logic [15:0] key_length;
    logic        last_result;
  } tshp_out_t;

  // Work sent from the parser to the emitter for one item
  typedef struct packed {
    logic        has_key;
    logic [7:0]  key_byte;
    logic        has_sum;
    tshp_out_t   summary;
  } tshp_work_t;

  localparam logic [15:0] KEY_CAP_RESET = 16'd133;
  localparam logic [7:0]  MSG_SERVER_HELLO = 8'h02;
  localparam logic [15:0] EXT_SUPPORTED_VERSIONS = 16'h002b;
  localparam logic [15:0] EXT_KEY_SHARE = 16'h0033;
  localparam logic [15:0] VERSION_TLS13 = 16'h0304;
  localparam logic        KIND_KEY = 1'b0;
  localparam logic        KIND_SUMMARY = 1'b1;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW = 2;
endpackage
`default_nettype wire

@@ hw/rtl/tshp_front.sv @@
// Front end: parses each byte and produces the work for that item
`default_nettype none
module tshp_front import tshp_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire tshp_in_t   item,
  input  wire logic [15:0] key_cap,
  output tshp_work_t      work
);
  typedef enum logic [3:0] {
    PH_TYPE, PH_LEN, PH_SKIP, PH_SIDLEN, PH_SID, PH_CIPHER, PH_COMP,
    PH_EXTLEN, PH_EXTHDR, PH_EXTDATA, PH_DONE, PH_ERR
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [15:0] fcnt_r, fcnt_nxt;
  logic [23:0] body_r, body_nxt;
  logic [15:0] extrem_r, extrem_nxt;
  logic [15:0] etype_r, etype_nxt;
  logic [15:0] elen_r, elen_nxt;
  logic [15:0] edleft_r, edleft_nxt;
  logic [15:0] kleft_r, kleft_nxt;
  logic [7:0]  sid_r, sid_nxt;
  logic [15:0] scr_r, scr_nxt;
  logic [15:0] cipher_r, cipher_nxt;
  logic [15:0] group_r, group_nxt;
  logic        ver_r, ver_nxt;
  logic [15:0] klen_r, klen_nxt;
  logic        err_r, err_nxt;

  logic [7:0]  b;
  logic [15:0] scr_sh;
  logic [15:0] extrem_dec;
  logic [16:0] kl_need;
  logic        bad;

  always_comb begin
    b = item.data_byte;
    phase_nxt = phase_r; fcnt_nxt = fcnt_r; body_nxt = body_r;
    extrem_nxt = extrem_r; etype_nxt = etype_r; elen_nxt = elen_r;
    edleft_nxt = edleft_r; kleft_nxt = kleft_r; sid_nxt = sid_r;
    scr_nxt = scr_r; cipher_nxt = cipher_r; group_nxt = group_r;
    ver_nxt = ver_r; klen_nxt = klen_r; err_nxt = err_r;
    scr_sh = {scr_r[7:0], b};
    extrem_dec = extrem_r - 16'd1;
    kl_need = 17'd4 + {1'b0, scr_sh};
    work = '0;

    if (phase_r >= PH_SKIP && phase_r <= PH_DONE && body_r != 24'd0)
      body_nxt = body_r - 24'd1;

    case (phase_r)
      PH_TYPE: begin
        if (b == MSG_SERVER_HELLO) begin
          phase_nxt = PH_LEN; fcnt_nxt = '0; body_nxt = '0;
        end else begin
          err_nxt = 1'b1; phase_nxt = PH_ERR;
        end
      end
      PH_LEN: begin
        body_nxt = {body_r[15:0], b};
        fcnt_nxt = fcnt_r + 16'd1;
        if (fcnt_r == 16'd2) begin
          if ({body_r[15:0], b} < 24'd35) begin
            err_nxt = 1'b1; phase_nxt = PH_ERR;
          end else begin
            phase_nxt = PH_SKIP; fcnt_nxt = '0;
          end
        end
      end
      PH_SKIP: begin
        fcnt_nxt = fcnt_r + 16'd1;
        if (fcnt_r >= 16'd33) phase_nxt = PH_SIDLEN;
      end
      PH_SIDLEN: begin
        sid_nxt = b;
        if (body_nxt < {16'd0, b} + 24'd3) begin
          err_nxt = 1'b1; phase_nxt = PH_ERR;
        end else begin
          fcnt_nxt = '0;
          phase_nxt = (b == 8'd0) ? PH_CIPHER : PH_SID;
        end
      end
      PH_SID: begin
        sid_nxt = sid_r - 8'd1;
        if (sid_r == 8'd1) begin
          phase_nxt = PH_CIPHER; fcnt_nxt = '0;
        end
      end
      PH_CIPHER: begin
        scr_nxt = scr_sh;
        fcnt_nxt = fcnt_r + 16'd1;
        if (fcnt_r >= 16'd1) begin
          cipher_nxt = scr_sh; phase_nxt = PH_COMP;
        end
      end
      PH_COMP: begin
        if (body_nxt < 24'd2) begin
          err_nxt = 1'b1; phase_nxt = PH_ERR;
        end else begin
          phase_nxt = PH_EXTLEN; fcnt_nxt = '0;
        end
      end
      PH_EXTLEN: begin
        scr_nxt = scr_sh;
        fcnt_nxt = fcnt_r + 16'd1;
        if (fcnt_r >= 16'd1) begin
          extrem_nxt = scr_sh;
          if ({8'd0, scr_sh} > body_nxt) begin
            err_nxt = 1'b1; phase_nxt = PH_ERR;
          end else begin
            kleft_nxt = '0; fcnt_nxt = '0;
            phase_nxt = (scr_sh < 16'd4) ? PH_DONE : PH_EXTHDR;
          end
        end
      end
      PH_EXTHDR: begin
        extrem_nxt = extrem_dec;
        fcnt_nxt = fcnt_r + 16'd1;
        if (fcnt_r <= 16'd1) etype_nxt = {etype_r[7:0], b};
        else elen_nxt = {elen_r[7:0], b};
        if (fcnt_r >= 16'd3) begin
          if (elen_nxt > extrem_dec) begin
            err_nxt = 1'b1; phase_nxt = PH_ERR;
          end else begin
            edleft_nxt = elen_nxt; kleft_nxt = '0; fcnt_nxt = '0;
            if (elen_nxt == 16'd0)
              phase_nxt = (extrem_dec < 16'd4) ? PH_DONE : PH_EXTHDR;
            else
              phase_nxt = PH_EXTDATA;
          end
        end
      end
      PH_EXTDATA: begin
        extrem_nxt = extrem_dec;
        edleft_nxt = edleft_r - 16'd1;
        fcnt_nxt = fcnt_r + 16'd1;
        scr_nxt = scr_sh;
        if (etype_r == EXT_SUPPORTED_VERSIONS && elen_r == 16'd2) begin
          if (fcnt_r == 16'd1 && scr_sh == VERSION_TLS13) ver_nxt = 1'b1;
        end else if (etype_r == EXT_KEY_SHARE && elen_r >= 16'd4) begin
          if (fcnt_r == 16'd1) group_nxt = scr_sh;
          else if (fcnt_r == 16'd3) begin
            if (kl_need <= {1'b0, elen_r} && scr_sh <= key_cap) begin
              klen_nxt = scr_sh; kleft_nxt = scr_sh;
            end
          end else if (fcnt_r >= 16'd4 && kleft_r != 16'd0) begin
            kleft_nxt = kleft_r - 16'd1;
            work.has_key = 1'b1;
            work.key_byte = b;
          end
        end
        if (edleft_r == 16'd1) begin
          kleft_nxt = '0; fcnt_nxt = '0;
          phase_nxt = (extrem_dec < 16'd4) ? PH_DONE : PH_EXTHDR;
        end
      end
      default: ;
    endcase

    bad = err_nxt || phase_nxt == PH_TYPE || phase_nxt == PH_LEN || body_nxt != 24'd0;
    if (item.end_of_message) begin
      work.has_sum = 1'b1;
      work.summary.result_kind = KIND_SUMMARY;
      work.summary.status = bad;
      work.summary.suite_id = cipher_nxt;
      work.summary.is_version_13 = ver_nxt;
      work.summary.key_group = group_nxt;
      work.summary.key_length = klen_nxt;
      work.summary.last_result = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && item.end_of_message)) begin
      phase_r <= PH_TYPE; fcnt_r <= '0; body_r <= '0; extrem_r <= '0;
      etype_r <= '0; elen_r <= '0; edleft_r <= '0; kleft_r <= '0;
      sid_r <= '0; scr_r <= '0; cipher_r <= '0; group_r <= '0;
      ver_r <= 1'b0; klen_r <= '0; err_r <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt; fcnt_r <= fcnt_nxt; body_r <= body_nxt;
      extrem_r <= extrem_nxt; etype_r <= etype_nxt; elen_r <= elen_nxt;
      edleft_r <= edleft_nxt; kleft_r <= kleft_nxt; sid_r <= sid_nxt;
      scr_r <= scr_nxt; cipher_r <= cipher_nxt; group_r <= group_nxt;
      ver_r <= ver_nxt; klen_r <= klen_nxt; err_r <= err_nxt;
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/tshp_queue.sv @@
// Work queue between the parser and the result emitter
`default_nettype none
module tshp_queue import tshp_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire tshp_work_t push_data,
  output logic            full,
  input  wire logic       pop,
  output logic            empty,
  output tshp_work_t      head
);
  tshp_work_t         mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wp_r, rp_r;
  logic [QUEUE_AW:0]   cnt_r;

  assign full = cnt_r == (QUEUE_AW+1)'(QUEUE_DEPTH);
  assign empty = cnt_r == '0;
  assign head = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + {{QUEUE_AW{1'b0}}, push} - {{QUEUE_AW{1'b0}}, pop};
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/tshp_back.sv @@
// Back end: turns each work entry into zero, one or two result items
`default_nettype none
module tshp_back import tshp_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       empty,
  input  wire tshp_work_t head,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output tshp_out_t       out_data
);
  logic      key_done_r, key_done_nxt;
  logic      send_key;
  tshp_out_t key_res;

  always_comb begin
    send_key = head.has_key && !key_done_r;
    key_res = '0;
    key_res.result_kind = KIND_KEY;
    key_res.key_byte = head.key_byte;
    key_res.last_result = !head.has_sum;
    out_valid = !empty && (send_key || head.has_sum);
    out_data = send_key ? key_res : head.summary;
    // drop entries with nothing to say; hold after a key byte if a summary follows
    pop = !empty && (!(send_key || head.has_sum) ||
          (out_ready && (!send_key || !head.has_sum)));
    key_done_nxt = key_done_r;
    if (pop) key_done_nxt = 1'b0;
    else if (out_valid && out_ready && send_key) key_done_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) key_done_r <= 1'b0;
    else key_done_r <= key_done_nxt;
  end
endmodule
`default_nettype wire

@@ hw/rtl/tls13_server_hello_parser.sv @@
// Top level: TLS 1.3 ServerHello parser, one byte per item
//   channel  | direction | handshake           | payload
//   in_      | input     | in_valid/in_ready   | tshp_in_t
//   out_     | output    | out_valid/out_ready | tshp_out_t
//   cfg_     | input     | cfg_we              | key_cap (16 bit)
// One item a cycle while the queue is not full; the parser's work for each byte is combinational.
// Results leave through a four-entry queue; in_ready drops only when it is full.
// A byte that gives a key byte and a summary yields the key byte result, then the summary.
// Reset is synchronous: parser state cleared, key_cap back to 133.
`default_nettype none
`include "assert_macros.svh"
module tls13_server_hello_parser import tshp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire tshp_in_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output tshp_out_t        out_data,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);
  logic [15:0] key_cap_r;
  logic        full, empty, pop, step;
  tshp_work_t  work, head;

  assign in_ready = !full;
  assign step = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) key_cap_r <= KEY_CAP_RESET;
    else if (cfg_we) key_cap_r <= cfg_wdata;
  end

  tshp_front u_front (.clk, .rst_n, .step, .item(in_data), .key_cap(key_cap_r), .work);
  tshp_queue u_queue (.clk, .rst_n, .push(step), .push_data(work), .full, .pop,
                      .empty, .head);
  tshp_back  u_back  (.clk, .rst_n, .empty, .head, .pop, .out_valid, .out_ready,
                      .out_data);

  `ASSERT_IMPL(a_no_pop_empty, clk, rst_n, pop, !empty, "pop from empty queue")
  `ASSERT_IMPL(a_sum_last, clk, rst_n, out_valid && out_data.result_kind == KIND_SUMMARY,
               out_data.last_result, "summary not marked last")
  `ASSERT_NEXT(a_full_block, clk, rst_n, full && !pop, !in_ready, "accept while full")
endmodule
`default_nettype wire
